// ===== hw/rtl/frm_pkg.sv =====
package frm_pkg;

  localparam int TIME_BITS = 48;
  localparam int PERIOD_W  = 16;
  localparam int MIN_W     = 20;
  localparam int FPS_W     = 16;
  localparam int WAIT_W    = 20;
  localparam int CNT_W     = 32;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam int US_W     = 20;
  localparam int MS_W     = 10;
  localparam int THR_W    = PERIOD_W + MS_W;
  localparam int PROD_W   = CNT_W + US_W;
  localparam int DSH_W    = TIME_BITS + FPS_W;
  localparam int CMP_W    = (DSH_W > PROD_W) ? DSH_W : PROD_W;
  localparam int DCNT_W   = $clog2(FPS_W + 1);

  localparam logic [US_W-1:0]     US_PER_S     = US_W'(1000000);
  localparam logic [MS_W-1:0]     US_PER_MS    = MS_W'(1000);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(1000);
  localparam logic [CNT_W-1:0]    COUNT_MAX    = '1;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [FPS_W-1:0]     fps_t;
  typedef logic [WAIT_W-1:0]    wait_t;
  typedef logic [CFG_W-1:0]     cfg_data_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REPORT_PERIOD = 2'd0,
    REG_MIN_FRAME     = 2'd1
  } cfg_index_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_EVAL = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

endpackage

// ===== hw/rtl/frm_if.sv =====
interface frm_frame_if;
  import frm_pkg::*;

  logic  valid;
  logic  ready;
  time_t now_us;

  modport source (output valid, output now_us, input ready);
  modport sink (input valid, input now_us, output ready);
endinterface

interface frm_report_if;
  import frm_pkg::*;

  logic  valid;
  logic  ready;
  fps_t  fps_value;
  logic  fps_updated;
  wait_t wait_us;

  modport source (output valid, output fps_value, output fps_updated, output wait_us,
                  input ready);
  modport sink (input valid, input fps_value, input fps_updated, input wait_us,
                output ready);
endinterface

// ===== hw/rtl/frame_rate_meter_limiter_core.sv =====
// Frame rate meter with frame limiter. Each frame beat carries a microsecond
// time stamp and yields one report beat with the current fps, a flag when the
// fps was recomputed, and the wait needed to keep frames min_frame_us apart.
// Items are handled one at a time: a frame with no fps update passes the
// load, evaluate and done states from accept to report; a frame that
// recomputes the fps also passes the divide state, since the quotient comes
// from one shared compare-and-subtract unit that runs up to 17 steps (a
// saturation check, then one quotient bit per step); a saturated fps ends
// after the check. A report beat left waiting on the output holds the next
// report back, not the next accept. Configuration writes take effect at
// once and are meant for idle times only.
module frame_rate_meter_limiter_core (
  input  logic                      clk,
  input  logic                      rst,
  frm_frame_if.sink                 frame,
  frm_report_if.source              report,
  input  logic                      cfg_we,
  input  logic [frm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  frm_pkg::cfg_data_t        cfg_data
);
  import frm_pkg::*;

  state_t               state;
  logic [PERIOD_W-1:0]  report_period_ms;
  logic [MIN_W-1:0]     min_frame_us;

  time_t                last_report_time;
  time_t                last_frame_time;
  logic [CNT_W-1:0]     frame_count;
  fps_t                 current_fps;

  time_t                now;
  time_t                since_report;
  time_t                since_frame;
  logic [THR_W-1:0]     threshold;
  logic                 upd;
  wait_t                wait_val;
  logic [PROD_W-1:0]    rem;
  logic [DSH_W-1:0]     dsh;
  logic [DCNT_W-1:0]    div_cnt;
  fps_t                 quot;
  logic                 sat;

  logic                 out_valid;
  fps_t                 out_fps;
  logic                 out_upd;
  wait_t                out_wait;

  // shared compare-and-subtract unit
  logic [CMP_W-1:0]     cmp_a;
  logic [CMP_W-1:0]     cmp_b;
  logic                 ge;
  logic [PROD_W-1:0]    rem_sub;

  assign cmp_a   = CMP_W'(rem);
  assign cmp_b   = CMP_W'(dsh);
  assign ge      = (cmp_a >= cmp_b);
  assign rem_sub = rem - dsh[PROD_W-1:0];

  logic report_free;
  assign report_free = !out_valid || report.ready;

  assign frame.ready        = (state == S_IDLE);
  assign report.valid       = out_valid;
  assign report.fps_value   = out_fps;
  assign report.fps_updated = out_upd;
  assign report.wait_us     = out_wait;

  fps_t new_fps;
  assign new_fps = sat ? '1 : quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      report_period_ms <= PERIOD_RESET;
      min_frame_us     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REPORT_PERIOD: report_period_ms <= cfg_data[PERIOD_W-1:0];
        REG_MIN_FRAME:     min_frame_us     <= cfg_data[MIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      last_report_time <= '0;
      last_frame_time  <= '0;
      frame_count      <= '0;
      current_fps      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if ((state == S_DONE) && report_free) out_valid <= 1'b1;
      else if (report.ready) out_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (frame.valid) begin
            now   <= frame.now_us;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          since_report <= now - last_report_time;
          since_frame  <= now - last_frame_time;
          threshold    <= {{MS_W{1'b0}}, report_period_ms} * {{PERIOD_W{1'b0}}, US_PER_MS};
          state        <= S_EVAL;
        end
        S_EVAL: begin
          upd <= (since_report != '0) && (since_report >= TIME_BITS'(threshold));
          rem <= {{US_W{1'b0}}, frame_count} * {{CNT_W{1'b0}}, US_PER_S};
          dsh <= {since_report, {FPS_W{1'b0}}};
          div_cnt <= DCNT_W'(FPS_W);
          sat     <= 1'b0;
          quot    <= '0;
          if ((min_frame_us != '0) && (since_frame != '0)
              && (since_frame < TIME_BITS'(min_frame_us)))
            wait_val <= min_frame_us - since_frame[MIN_W-1:0];
          else
            wait_val <= '0;
          if ((since_report != '0) && (since_report >= TIME_BITS'(threshold)))
            state <= S_DIV;
          else
            state <= S_DONE;
        end
        S_DIV: begin
          dsh <= dsh >> 1;
          div_cnt <= div_cnt - DCNT_W'(1);
          if (div_cnt == DCNT_W'(FPS_W)) begin
            // quotient would not fit in fps width
            if (ge) begin
              sat   <= 1'b1;
              state <= S_DONE;
            end
          end else begin
            quot <= {quot[FPS_W-2:0], ge};
            if (ge) rem <= rem_sub;
            if (div_cnt == '0) state <= S_DONE;
          end
        end
        S_DONE: begin
          if (report_free) begin
            out_upd   <= upd;
            out_wait  <= wait_val;
            if (upd) begin
              current_fps      <= new_fps;
              out_fps          <= new_fps;
              last_report_time <= now;
              frame_count      <= '0;
            end else begin
              out_fps <= current_fps;
              if (frame_count != COUNT_MAX) frame_count <= frame_count + CNT_W'(1);
            end
            if (min_frame_us != '0) last_frame_time <= now + TIME_BITS'(wait_val);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_frame_rate_meter_limiter_core.sv =====
module tb_frame_rate_meter_limiter_core;
  import frm_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int RANDOM_FRAMES = 2000;
  localparam int STALL_CYCLES  = 300;

  typedef struct packed {
    fps_t  fps_value;
    logic  fps_updated;
    wait_t wait_us;
  } report_t;

  typedef enum logic {ROW_FRAME, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    cfg_data_t             data;
    time_t                 stamp;
    logic                  typed;
    report_t               rep;
  } stim_row_t;

  localparam int DIR_ROWS = 26;

  logic      clk;
  logic      rst;
  logic      cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  cfg_data_t cfg_data;

  frm_frame_if  frame_ch ();
  frm_report_if report_ch ();

  frame_rate_meter_limiter_core u_top (
    .clk       (clk),
    .rst       (rst),
    .frame     (frame_ch),
    .report    (report_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // rate meter state mirrored on the testbench side
  logic [PERIOD_W-1:0] period_ms_cfg = PERIOD_RESET;
  logic [MIN_W-1:0]    min_gap_us    = '0;
  time_t               rpt_time      = '0;
  time_t               frm_time      = '0;
  logic [CNT_W-1:0]    frames_seen   = '0;
  fps_t                fps_now       = '0;

  report_t   expected_reports [$];
  stim_row_t dir_rows [DIR_ROWS];
  int        errors       = 0;
  int        reports_seen = 0;
  bit        steady       = 1'b0;
  bit        held         = 1'b0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("** frame_rate_meter_limiter_core: FAILED **");
    $finish;
  end

  function automatic report_t predict_report(input time_t stamp);
    report_t     r;
    time_t       since_rpt;
    time_t       since_frm;
    logic [63:0] thr;
    logic [63:0] quot;
    r = '0;
    since_rpt = stamp - rpt_time;
    thr = 64'(period_ms_cfg) * 64'(US_PER_MS);
    if (since_rpt != '0 && 64'(since_rpt) >= thr) begin
      quot = (64'(frames_seen) * 64'(US_PER_S)) / 64'(since_rpt);
      fps_now = (quot > 64'(fps_t'('1))) ? '1 : quot[FPS_W-1:0];
      rpt_time = stamp;
      frames_seen = '0;
      r.fps_updated = 1'b1;
    end else if (frames_seen != COUNT_MAX) begin
      frames_seen = frames_seen + CNT_W'(1);
    end
    if (min_gap_us != '0) begin
      since_frm = stamp - frm_time;
      if (since_frm != '0 && since_frm < time_t'(min_gap_us))
        r.wait_us = min_gap_us - since_frm[WAIT_W-1:0];
      frm_time = stamp + time_t'(r.wait_us);
    end
    r.fps_value = fps_now;
    return r;
  endfunction

  function automatic bit roll_idle();
    return !steady && ($urandom_range(99) < 23);
  endfunction

  // one frame beat; entered and left at a falling edge
  task automatic send_frame(input time_t stamp, input bit typed, input report_t typed_rep);
    report_t predicted;
    while (roll_idle()) begin
      frame_ch.valid <= 1'b0;
      @(negedge clk);
    end
    frame_ch.valid  <= 1'b1;
    frame_ch.now_us <= stamp;
    do @(posedge clk); while (!frame_ch.ready);
    predicted = predict_report(stamp);
    expected_reports.push_back(typed ? typed_rep : predicted);
    @(negedge clk);
  endtask

  // register writes only once the block has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input cfg_data_t data);
    frame_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_REPORT_PERIOD)
      period_ms_cfg = data[PERIOD_W-1:0];
    else if (idx == REG_MIN_FRAME)
      min_gap_us = data[MIN_W-1:0];
  endtask

  // receiver with one long hold-off to back the block up
  initial begin
    report_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && reports_seen >= 400) begin
        held = 1'b1;
        repeat (STALL_CYCLES) begin
          report_ch.ready <= 1'b0;
          @(negedge clk);
        end
      end
      report_ch.ready <= !roll_idle();
    end
  end

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (!rst && report_ch.valid && report_ch.ready) begin
      got = '{report_ch.fps_value, report_ch.fps_updated, report_ch.wait_us};
      reports_seen++;
      if (expected_reports.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected report beat: fps %0d upd %0d wait %0d",
                   got.fps_value, got.fps_updated, got.wait_us);
      end else begin
        want = expected_reports.pop_front();
        if (got.fps_value != want.fps_value || got.fps_updated != want.fps_updated ||
            got.wait_us != want.wait_us) begin
          errors++;
          if (errors <= 10)
            $display("report mismatch at %0t: fps %0d/%0d upd %0d/%0d wait %0d/%0d (exp/got)",
                     $realtime, want.fps_value, got.fps_value, want.fps_updated,
                     got.fps_updated, want.wait_us, got.wait_us);
        end
      end
    end
  end

  initial begin : stimulus
    logic [PERIOD_W-1:0] period_pick;
    logic [MIN_W-1:0]    min_pick;
    int unsigned         step_hi;
    int unsigned         phase_len;
    int unsigned         roll;
    int                  sent;
    time_t               stamp;

    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    frame_ch.valid  = 1'b0;
    frame_ch.now_us = '0;

    dir_rows = '{
      // default period, frame counting and a first update
      '{ROW_FRAME, '0, '0, 48'd0,             1'b1, '{16'd0, 1'b0, 20'd0}},
      '{ROW_FRAME, '0, '0, 48'd0,             1'b1, '{16'd0, 1'b0, 20'd0}},
      '{ROW_FRAME, '0, '0, 48'd999_999,       1'b1, '{16'd0, 1'b0, 20'd0}},
      '{ROW_FRAME, '0, '0, 48'd1_000_000,     1'b1, '{16'd3, 1'b1, 20'd0}},
      '{ROW_FRAME, '0, '0, 48'd1_000_000,     1'b1, '{16'd3, 1'b0, 20'd0}},
      '{ROW_FRAME, '0, '0, 48'hFFFF_FFFF_FFFF, 1'b1, '{16'd0, 1'b1, 20'd0}},
      // stamp wraps forward by one
      '{ROW_FRAME, '0, '0, 48'd0,             1'b1, '{16'd0, 1'b0, 20'd0}},
      '{ROW_CFG, REG_REPORT_PERIOD, 20'd0, '0, 1'b0, '0},
      // zero period, fps saturation
      '{ROW_FRAME, '0, '0, 48'd0,             1'b1, '{16'd65535, 1'b1, 20'd0}},
      '{ROW_FRAME, '0, '0, 48'd0,             1'b1, '{16'd65535, 1'b0, 20'd0}},
      '{ROW_FRAME, '0, '0, 48'd5,             1'b1, '{16'd65535, 1'b1, 20'd0}},
      '{ROW_FRAME, '0, '0, 48'd2_000_005,     1'b1, '{16'd0, 1'b1, 20'd0}},
      // time going backwards
      '{ROW_FRAME, '0, '0, 48'd1_000_000,     1'b1, '{16'd0, 1'b1, 20'd0}},
      '{ROW_CFG, REG_REPORT_PERIOD, 20'd65535, '0, 1'b0, '0},
      '{ROW_CFG, REG_MIN_FRAME, 20'd1_000_000, '0, 1'b0, '0},
      // write to a missing register must not land anywhere
      '{ROW_CFG, REG_SPARE, 20'd0, '0, 1'b0, '0},
      '{ROW_FRAME, '0, '0, 48'd1_000_000,     1'b1, '{16'd0, 1'b0, 20'd0}},
      '{ROW_FRAME, '0, '0, 48'd1_000_001,     1'b1, '{16'd0, 1'b0, 20'd999_999}},
      '{ROW_FRAME, '0, '0, 48'd1_500_000,     1'b1, '{16'd0, 1'b0, 20'd0}},
      '{ROW_FRAME, '0, '0, 48'd1_500_000,     1'b1, '{16'd0, 1'b0, 20'd0}},
      '{ROW_FRAME, '0, '0, 48'd66_535_000,    1'b1, '{16'd0, 1'b1, 20'd0}},
      '{ROW_CFG, REG_REPORT_PERIOD, 20'd1, '0, 1'b0, '0},
      '{ROW_CFG, REG_MIN_FRAME, 20'd16_667, '0, 1'b0, '0},
      '{ROW_FRAME, '0, '0, 48'd66_536_000,    1'b0, '0},
      '{ROW_FRAME, '0, '0, 48'd66_540_000,    1'b0, '0},
      '{ROW_FRAME, '0, '0, 48'd66_545_000,    1'b0, '0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      else
        send_frame(dir_rows[i].stamp, dir_rows[i].typed, dir_rows[i].rep);
    end

    sent  = 0;
    stamp = 48'd66_545_000;
    while (sent < RANDOM_FRAMES) begin
      case ($urandom_range(5))
        0:       period_pick = '0;
        1:       period_pick = 16'd1;
        2:       period_pick = PERIOD_W'($urandom_range(2, 20));
        3:       period_pick = PERIOD_RESET;
        4:       period_pick = '1;
        default: period_pick = PERIOD_W'($urandom_range(0, 65535));
      endcase
      // about eight frames per report period unless overridden
      step_hi = 32'(period_pick) * 250 + 1;
      if ($urandom_range(9) < 3) begin
        case ($urandom_range(3))
          0:       step_hi = 8;
          1:       step_hi = 500;
          2:       step_hi = 50_000;
          default: step_hi = 2_000_000;
        endcase
      end
      case ($urandom_range(4))
        0:       min_pick = '0;
        1:       min_pick = 20'd1;
        2:       min_pick = 20'd1_000_000;
        3:       min_pick = MIN_W'($urandom_range(1, (step_hi * 2 > 1_000_000) ?
                                                     1_000_000 : step_hi * 2));
        default: min_pick = MIN_W'($urandom_range(0, 1_000_000));
      endcase
      write_reg(REG_REPORT_PERIOD, cfg_data_t'(period_pick));
      write_reg(REG_MIN_FRAME, cfg_data_t'(min_pick));
      if ($urandom_range(3) == 0)
        write_reg(REG_SPARE, cfg_data_t'($urandom));

      phase_len = $urandom_range(40, 200);
      repeat (phase_len) begin
        roll = $urandom_range(99);
        if (roll < 3)
          stamp = time_t'({$urandom, $urandom});
        else if (roll < 5)
          stamp = stamp - time_t'($urandom_range(1, step_hi));
        else if (roll >= 10)
          stamp = stamp + time_t'($urandom_range(1, step_hi));
        steady = (sent >= 900 && sent < 1300);
        send_frame(stamp, 1'b0, '0);
        sent++;
      end
    end

    steady = 1'b0;
    frame_ch.valid <= 1'b0;
    while (expected_reports.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0)
      $display("** frame_rate_meter_limiter_core: PASSED **");
    else
      $display("** frame_rate_meter_limiter_core: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/frm_pkg.sv
hw/rtl/frm_if.sv
hw/rtl/frame_rate_meter_limiter_core.sv
tb/sv/tb_frame_rate_meter_limiter_core.sv
